>>> sv/best_fit_extent_index_table_unit_assert.svh
// Assertion macros shared by the extent index table RTL.
`ifndef BEST_FIT_EXTENT_INDEX_TABLE_UNIT_ASSERT_SVH
`define BEST_FIT_EXTENT_INDEX_TABLE_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BFEIT_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("extent table assertion failed");

// Next-cycle implication, checked outside reset.
`define BFEIT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("extent table assertion failed");

`endif

>>> sv/bfeit_pkg.sv
// Types and constants shared by the extent index table modules.
`default_nettype none

package bfeit_pkg;

  localparam int unsigned KEY_W  = 32;
  localparam int unsigned KIND_W = 8;
  localparam int unsigned OFF_W  = 32;
  localparam int unsigned LEN_W  = 32;
  localparam int unsigned SLOT_W = 8;

  localparam logic [OFF_W-1:0] START_OFFSET_RESET = 32'd16;

  typedef enum logic [1:0] {
    ACT_LOOKUP     = 2'd0,
    ACT_STORE      = 2'd1,
    ACT_ERASE      = 2'd2,
    ACT_DELETE_ALL = 2'd3
  } act_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_MISS     = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_ZERO_KEY = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    MODE_MATCH = 2'd0,
    MODE_KEY   = 2'd1,
    MODE_FIT   = 2'd2
  } eval_mode_e;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [KIND_W-1:0] kind;
    logic [OFF_W-1:0]  offset;
    logic [LEN_W-1:0]  length;
  } entry_t;

  typedef struct packed {
    logic             hit;
    logic             exact;
    logic [LEN_W-1:0] spare;
  } eval_t;

endpackage

`default_nettype wire

>>> sv/bfeit_table.sv
// Entry memory: one write port and one registered read port.
`default_nettype none

module bfeit_table import bfeit_pkg::*; #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  wire logic          clk_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output entry_t             rdata_o,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire entry_t        wdata_i
);

  entry_t mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> sv/bfeit_eval.sv
// Shared entry evaluation unit: key/kind match and best-fit spare compare.
`default_nettype none

module bfeit_eval import bfeit_pkg::*; (
  input  wire eval_mode_e         mode_i,
  input  wire entry_t             entry_i,
  input  wire logic [KEY_W-1:0]   key_i,
  input  wire logic [KIND_W-1:0]  kind_i,
  input  wire logic [LEN_W-1:0]   size_i,
  input  wire logic               have_best_i,
  input  wire logic [LEN_W-1:0]   best_spare_i,
  output eval_t                   result_o
);

  logic [LEN_W:0] diff;
  logic           key_eq;
  logic           kind_eq;
  logic           fits;
  logic           better;

  assign diff    = {1'b0, entry_i.length} - {1'b0, size_i};
  assign key_eq  = (entry_i.key == key_i);
  assign kind_eq = (entry_i.kind == kind_i);
  assign fits    = ~diff[LEN_W];
  assign better  = ~have_best_i || (diff[LEN_W-1:0] < best_spare_i);

  always_comb begin
    result_o.spare = diff[LEN_W-1:0];
    result_o.exact = (diff == '0);
    case (mode_i)
      MODE_MATCH: result_o.hit = key_eq && kind_eq;
      MODE_KEY:   result_o.hit = key_eq;
      MODE_FIT:   result_o.hit = (entry_i.key == '0) && fits && better;
      default:    result_o.hit = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

>>> sv/best_fit_extent_index_table_unit.sv
// Top level of the best-fit extent index table.
`default_nettype none

`include "best_fit_extent_index_table_unit_assert.svh"

// The block keeps a table of extents (key, kind, offset, length) in a single-port
// read / single-port write memory, and handles one transaction at a time. A
// sequencer walks the live entries one per cycle through a registered memory
// read and one shared evaluation unit that does the key/kind match or the
// best-fit spare compare. Lookup and erase stop early on the first match;
// delete-all walks every live entry; store may walk the table twice, once to
// find a match and once more for the best free fit, which stops early on an
// exact fit. A delete-all with key zero is refused without a walk.
// Each
// input transaction gives exactly one result transaction, held in an output
// register, so a new input can be taken while the previous result waits. The
// entry memory is not cleared: only entries below entries_used are ever read.
// A write of the start offset register also sets the running end offset, but
// only while the table is empty.
module best_fit_extent_index_table_unit import bfeit_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 256
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // Configuration write.
  input  wire logic               cfg_we_i,
  input  wire logic [OFF_W-1:0]   cfg_wdata_i,
  // Input channel.
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [1:0]         action_i,
  input  wire logic [KEY_W-1:0]   key_i,
  input  wire logic [KIND_W-1:0]  kind_i,
  input  wire logic [LEN_W-1:0]   size_wanted_i,
  // Result channel.
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [1:0]              status_o,
  output logic [SLOT_W-1:0]       slot_o,
  output logic [OFF_W-1:0]        extent_offset_o,
  output logic [LEN_W-1:0]        extent_length_o
);

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_ENTRIES);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_LOOK  = 5'b00010,
    S_DEL   = 5'b00100,
    S_FIT   = 5'b01000,
    S_REPLY = 5'b10000
  } state_e;

  state_e             state_q, state_d;
  act_e               req_act_q, req_act_d;
  logic [KEY_W-1:0]   req_key_q, req_key_d;
  logic [KIND_W-1:0]  req_kind_q, req_kind_d;
  logic [LEN_W-1:0]   req_size_q, req_size_d;

  // Scan pointer and the one read that is in flight.
  logic [CNT_W-1:0]   rd_idx_q, rd_idx_d;
  logic               ev_vld_q, ev_vld_d;
  logic [IDX_W-1:0]   ev_idx_q, ev_idx_d;

  // Best free fit found so far.
  logic               have_best_q, have_best_d;
  logic [IDX_W-1:0]   best_idx_q, best_idx_d;
  logic [LEN_W-1:0]   best_spare_q, best_spare_d;
  logic [OFF_W-1:0]   best_off_q, best_off_d;
  logic [LEN_W-1:0]   best_len_q, best_len_d;

  logic               changed_q, changed_d;
  logic [CNT_W-1:0]   used_q, used_d;
  logic [OFF_W-1:0]   end_q, end_d;

  // Finished result, waiting for the output register.
  status_e            res_status_q, res_status_d;
  logic [IDX_W-1:0]   res_slot_q, res_slot_d;
  logic [OFF_W-1:0]   res_off_q, res_off_d;
  logic [LEN_W-1:0]   res_len_q, res_len_d;

  logic               out_valid_q;
  logic [1:0]         out_status_q;
  logic [SLOT_W-1:0]  out_slot_q;
  logic [OFF_W-1:0]   out_off_q;
  logic [LEN_W-1:0]   out_len_q;
  logic               out_free;
  logic               out_load;
  logic [IDX_W+SLOT_W-1:0] slot_wide;

  logic               mem_re;
  logic [IDX_W-1:0]   mem_raddr;
  entry_t             mem_rdata;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  entry_t             mem_wdata;

  eval_mode_e         eval_mode;
  eval_t              ev;
  logic               more;

  bfeit_table #(
    .DEPTH (TABLE_ENTRIES),
    .AW    (IDX_W)
  ) u_table (
    .clk_i   (clk_i),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata)
  );

  bfeit_eval u_eval (
    .mode_i       (eval_mode),
    .entry_i      (mem_rdata),
    .key_i        (req_key_q),
    .kind_i       (req_kind_q),
    .size_i       (req_size_q),
    .have_best_i  (have_best_q),
    .best_spare_i (best_spare_q),
    .result_o     (ev)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign more       = (rd_idx_q < used_q);
  assign out_free   = ~out_valid_q || ~out_stall_i;
  assign out_load   = (state_q == S_REPLY) && out_free;

  always_comb begin
    state_d      = state_q;
    req_act_d    = req_act_q;
    req_key_d    = req_key_q;
    req_kind_d   = req_kind_q;
    req_size_d   = req_size_q;
    rd_idx_d     = rd_idx_q;
    ev_vld_d     = ev_vld_q;
    ev_idx_d     = ev_idx_q;
    have_best_d  = have_best_q;
    best_idx_d   = best_idx_q;
    best_spare_d = best_spare_q;
    best_off_d   = best_off_q;
    best_len_d   = best_len_q;
    changed_d    = changed_q;
    used_d       = used_q;
    end_d        = end_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    res_off_d    = res_off_q;
    res_len_d    = res_len_q;
    mem_re       = 1'b0;
    mem_raddr    = rd_idx_q[IDX_W-1:0];
    mem_we       = 1'b0;
    mem_waddr    = ev_idx_q;
    mem_wdata    = mem_rdata;
    eval_mode    = MODE_MATCH;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_act_d   = act_e'(action_i);
          req_key_d   = key_i;
          req_kind_d  = kind_i;
          req_size_d  = size_wanted_i;
          rd_idx_d    = '0;
          ev_vld_d    = 1'b0;
          have_best_d = 1'b0;
          changed_d   = 1'b0;
          if (act_e'(action_i) == ACT_DELETE_ALL) begin
            if (key_i == '0) begin
              // A zero key would wipe every free entry's meaning; refuse it.
              res_status_d = STAT_ZERO_KEY;
              res_slot_d   = '0;
              res_off_d    = '0;
              res_len_d    = '0;
              state_d      = S_REPLY;
            end else begin
              state_d = S_DEL;
            end
          end else begin
            state_d = S_LOOK;
          end
        end
      end

      S_LOOK: begin
        eval_mode = MODE_MATCH;
        if (ev_vld_q && ev.hit) begin
          ev_vld_d     = 1'b0;
          res_status_d = STAT_OK;
          res_slot_d   = ev_idx_q;
          res_off_d    = mem_rdata.offset;
          res_len_d    = mem_rdata.length;
          state_d      = S_REPLY;
          case (req_act_q)
            ACT_ERASE: begin
              mem_we        = 1'b1;
              mem_wdata.key = '0;
            end
            ACT_STORE: begin
              if (!ev.exact) begin
                // Length changed: free the old extent and look for a new home.
                mem_we        = 1'b1;
                mem_wdata.key = '0;
                rd_idx_d      = '0;
                state_d       = S_FIT;
              end
            end
            default: begin
            end
          endcase
        end else if (more) begin
          mem_re   = 1'b1;
          ev_vld_d = 1'b1;
          ev_idx_d = rd_idx_q[IDX_W-1:0];
          rd_idx_d = rd_idx_q + CNT_W'(1);
        end else begin
          ev_vld_d = 1'b0;
          if (!ev_vld_q) begin
            if (req_act_q == ACT_STORE) begin
              rd_idx_d = '0;
              state_d  = S_FIT;
            end else begin
              res_status_d = STAT_MISS;
              res_slot_d   = '0;
              res_off_d    = '0;
              res_len_d    = '0;
              state_d      = S_REPLY;
            end
          end
        end
      end

      S_DEL: begin
        eval_mode = MODE_KEY;
        if (ev_vld_q && ev.hit) begin
          mem_we        = 1'b1;
          mem_wdata.key = '0;
          changed_d     = 1'b1;
        end
        if (more) begin
          mem_re   = 1'b1;
          ev_vld_d = 1'b1;
          ev_idx_d = rd_idx_q[IDX_W-1:0];
          rd_idx_d = rd_idx_q + CNT_W'(1);
        end else begin
          ev_vld_d = 1'b0;
          if (!ev_vld_q) begin
            res_status_d = changed_q ? STAT_OK : STAT_MISS;
            res_slot_d   = '0;
            res_off_d    = '0;
            res_len_d    = '0;
            state_d      = S_REPLY;
          end
        end
      end

      S_FIT: begin
        eval_mode = MODE_FIT;
        if (ev_vld_q && ev.hit) begin
          have_best_d  = 1'b1;
          best_idx_d   = ev_idx_q;
          best_spare_d = ev.spare;
          best_off_d   = mem_rdata.offset;
          best_len_d   = mem_rdata.length;
        end
        if (ev_vld_q && ev.hit && ev.exact) begin
          // Exact fit ends the search at once.
          ev_vld_d       = 1'b0;
          mem_we         = 1'b1;
          mem_wdata.key  = req_key_q;
          mem_wdata.kind = req_kind_q;
          res_status_d   = STAT_OK;
          res_slot_d     = ev_idx_q;
          res_off_d      = mem_rdata.offset;
          res_len_d      = mem_rdata.length;
          state_d        = S_REPLY;
        end else if (more) begin
          mem_re   = 1'b1;
          ev_vld_d = 1'b1;
          ev_idx_d = rd_idx_q[IDX_W-1:0];
          rd_idx_d = rd_idx_q + CNT_W'(1);
        end else begin
          ev_vld_d = 1'b0;
          if (!ev_vld_q) begin
            state_d = S_REPLY;
            if (have_best_q) begin
              mem_we           = 1'b1;
              mem_waddr        = best_idx_q;
              mem_wdata.key    = req_key_q;
              mem_wdata.kind   = req_kind_q;
              mem_wdata.offset = best_off_q;
              mem_wdata.length = best_len_q;
              res_status_d     = STAT_OK;
              res_slot_d       = best_idx_q;
              res_off_d        = best_off_q;
              res_len_d        = best_len_q;
            end else if (used_q == FULL_COUNT) begin
              res_status_d = STAT_FULL;
              res_slot_d   = '0;
              res_off_d    = '0;
              res_len_d    = '0;
            end else begin
              // Append a new extent at the running end offset.
              mem_we           = 1'b1;
              mem_waddr        = used_q[IDX_W-1:0];
              mem_wdata.key    = req_key_q;
              mem_wdata.kind   = req_kind_q;
              mem_wdata.offset = end_q;
              mem_wdata.length = req_size_q;
              used_d           = used_q + CNT_W'(1);
              end_d            = end_q + req_size_q;
              res_status_d     = STAT_OK;
              res_slot_d       = used_q[IDX_W-1:0];
              res_off_d        = end_q;
              res_len_d        = req_size_q;
            end
          end
        end
      end

      S_REPLY: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // The start offset only matters while nothing has been handed out yet.
    if (cfg_we_i && (used_q == '0)) begin
      end_d = cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ev_vld_q    <= 1'b0;
      have_best_q <= 1'b0;
      changed_q   <= 1'b0;
      used_q      <= '0;
      end_q       <= START_OFFSET_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ev_vld_q    <= ev_vld_d;
      have_best_q <= have_best_d;
      changed_q   <= changed_d;
      used_q      <= used_d;
      end_q       <= end_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign slot_wide = {{SLOT_W{1'b0}}, res_slot_q};

  always_ff @(posedge clk_i) begin
    req_act_q    <= req_act_d;
    req_key_q    <= req_key_d;
    req_kind_q   <= req_kind_d;
    req_size_q   <= req_size_d;
    rd_idx_q     <= rd_idx_d;
    ev_idx_q     <= ev_idx_d;
    best_idx_q   <= best_idx_d;
    best_spare_q <= best_spare_d;
    best_off_q   <= best_off_d;
    best_len_q   <= best_len_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    res_off_q    <= res_off_d;
    res_len_q    <= res_len_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_slot_q   <= slot_wide[SLOT_W-1:0];
      out_off_q    <= res_off_q;
      out_len_q    <= res_len_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign slot_o          = out_slot_q;
  assign extent_offset_o = out_off_q;
  assign extent_length_o = out_len_q;

  // The fill count never passes the table size.
  `BFEIT_ASSERT_IMPLIES(a_used_bound, clk_i, rst_ni, 1'b1, used_q <= FULL_COUNT)
  // The fill count only ever grows by one entry at a time.
  `BFEIT_ASSERT_IMPLIES(a_used_step, clk_i, rst_ni, used_q != $past(used_q), used_q == $past(used_q) + CNT_W'(1))
  // An accepted transaction always starts the sequencer.
  `BFEIT_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, in_valid_i && !in_stall_o, state_q != S_IDLE)
  // A finished result waits while the output register is still held.
  `BFEIT_ASSERT_NEXT(a_reply_holds, clk_i, rst_ni, (state_q == S_REPLY) && out_valid_q && out_stall_i, state_q == S_REPLY)

endmodule

`default_nettype wire
